// ===== rtl/rmw_pkg.sv =====
// Package for the region merge window test block.
// Holds the window geometry constants and the stage-1 word type.
// Depends on nothing.
package rmw_pkg;

	localparam int HIST_BITS = 32;
	localparam int WIN_SIZE  = 16;
	localparam int MAX_DIFF  = 2;
	localparam int MAP_BITS  = 32;
	localparam int NODE_W    = 11;
	localparam int CNT_W     = $clog2(WIN_SIZE + 1);

	// One lane per window start, starts 0 .. HIST_BITS-WIN_SIZE-1
	localparam int NUM_WIN   = HIST_BITS - WIN_SIZE;

	// Maps padded with zero slots when the histogram is wider than the maps
	localparam int EXT_W     = (HIST_BITS > MAP_BITS) ? HIST_BITS : MAP_BITS;

	// Reset value of node_count
	localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1);

	// Word handed from the lane stage to the output stage
	typedef struct packed {
		logic               valid;
		logic               node_ok;
		logic [NUM_WIN-1:0] fail;
	} s1_word_t;

endpackage

// ===== rtl/rmw_lane.sv =====
// One window lane: counts set slots of both maps in a 16-slot window.
// Flags the window when the counts differ by more than MAX_DIFF.
// Depends on rmw_pkg.
module rmw_lane (
	input  logic [rmw_pkg::WIN_SIZE-1:0] win_a,
	input  logic [rmw_pkg::WIN_SIZE-1:0] win_b,
	output logic                         fail
);

	logic [1:0] a1 [8];
	logic [1:0] b1 [8];
	logic [2:0] a2 [4];
	logic [2:0] b2 [4];
	logic [3:0] a3 [2];
	logic [3:0] b3 [2];
	logic [rmw_pkg::CNT_W-1:0] cnt_a;
	logic [rmw_pkg::CNT_W-1:0] cnt_b;
	logic [rmw_pkg::CNT_W-1:0] diff;

	// Add pairs of slots
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			a1[i] = 2'(win_a[2*i]) + 2'(win_a[2*i+1]);
			b1[i] = 2'(win_b[2*i]) + 2'(win_b[2*i+1]);
		end
	end

	// Add pairs of pair sums
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a2[i] = 3'(a1[2*i]) + 3'(a1[2*i+1]);
			b2[i] = 3'(b1[2*i]) + 3'(b1[2*i+1]);
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			a3[i] = 4'(a2[2*i]) + 4'(a2[2*i+1]);
			b3[i] = 4'(b2[2*i]) + 4'(b2[2*i+1]);
		end
	end

	assign cnt_a = rmw_pkg::CNT_W'(a3[0]) + rmw_pkg::CNT_W'(a3[1]);
	assign cnt_b = rmw_pkg::CNT_W'(b3[0]) + rmw_pkg::CNT_W'(b3[1]);

	// Absolute difference against the limit
	assign diff = (cnt_a > cnt_b) ? (cnt_a - cnt_b) : (cnt_b - cnt_a);
	assign fail = (diff > rmw_pkg::CNT_W'(rmw_pkg::MAX_DIFF));

endmodule

// ===== rtl/rmw_merge.sv =====
// Output stage: combines the lane flags and the node check into may_merge.
// Holds the result word until the receiver takes it.
// Depends on rmw_pkg.
module rmw_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  rmw_pkg::s1_word_t s1_word,
	input  logic              out_stall,
	output logic              advance,
	output logic              out_valid,
	output logic              may_merge
);

	logic out_valid_q;
	logic may_merge_q;

	// Load when the output register is empty or being taken
	assign advance = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_word.valid;
		end
	end

	// Merge only when both nodes are valid and no window failed
	always_ff @(posedge clk) begin
		if (advance && s1_word.valid) begin
			may_merge_q <= s1_word.node_ok && !(|s1_word.fail);
		end
	end

	assign out_valid = out_valid_q;
	assign may_merge = may_merge_q;

endmodule

// ===== rtl/region_merge_window_test.sv =====
// Region merge window test, top level.
// An accepted word passes the lane stage register and then the output stage register before its result word.
// Throughput: one word per cycle while the output is not stalled; the lanes count every window of a word at once.
// Reset: arst_n clears the pipeline valids and sets node_count to 1.
// node_count is taken at any cycle (cfg_ready is always high).
// Depends on rmw_pkg, rmw_lane, rmw_merge.
module region_merge_window_test (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rmw_pkg::NODE_W-1:0]        node_count,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rmw_pkg::MAP_BITS-1:0]      first_active_map,
	input  logic [rmw_pkg::MAP_BITS-1:0]      second_active_map,
	input  logic signed [rmw_pkg::NODE_W-1:0] first_node,
	input  logic signed [rmw_pkg::NODE_W-1:0] second_node,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              may_merge
);

	logic [rmw_pkg::NODE_W-1:0]  node_count_q;
	logic [rmw_pkg::EXT_W-1:0]   ext_a;
	logic [rmw_pkg::EXT_W-1:0]   ext_b;
	logic [rmw_pkg::NUM_WIN-1:0] lane_fail;
	logic                        node_ok;
	logic                        advance;
	logic                        en1;
	rmw_pkg::s1_word_t           word_s1;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= rmw_pkg::NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= node_count;
		end
	end

	// Node check: nonnegative and below node_count
	assign node_ok = !first_node[rmw_pkg::NODE_W-1] && !second_node[rmw_pkg::NODE_W-1]
		&& ($unsigned(first_node) < node_count_q)
		&& ($unsigned(second_node) < node_count_q);

	// Pad maps with zero slots up to the histogram width
	assign ext_a = rmw_pkg::EXT_W'(first_active_map);
	assign ext_b = rmw_pkg::EXT_W'(second_active_map);

	// One lane per window start
	for (genvar g = 0; g < rmw_pkg::NUM_WIN; g++) begin : g_lane
		rmw_lane u_lane (
			.win_a (ext_a[g +: rmw_pkg::WIN_SIZE]),
			.win_b (ext_b[g +: rmw_pkg::WIN_SIZE]),
			.fail  (lane_fail[g])
		);
	end

	// Advance stage 1 when it is empty or the output stage takes it
	assign en1      = !word_s1.valid || advance;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s1 <= '0;
		end else if (en1) begin
			word_s1.valid <= in_valid;
			if (in_valid) begin
				word_s1.node_ok <= node_ok;
				word_s1.fail    <= lane_fail;
			end
		end
	end

	rmw_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_word   (word_s1),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.may_merge (may_merge)
	);

	// Input stalls only when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && word_s1.valid))
		else $error("input stalled with room in the pipeline");

	// An accepted word lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> word_s1.valid)
		else $error("accepted word lost before stage 1");

	// A configuration write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> (node_count_q == $past(node_count)))
		else $error("node_count write not taken");

	// A bad node never yields a merge
	a_bad_node: assert property (@(posedge clk) disable iff (!arst_n)
		(word_s1.valid && !word_s1.node_ok && advance) |=> (out_valid && !may_merge))
		else $error("merge granted for an invalid node");

endmodule
